/* sv/rle_pkg.sv */
// Package of the RGB LED effect engine: types, codes, constants and the
// shared scaling helpers. No dependencies.
package rle_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int TIME_IN_W     = 32;
    localparam int COLOR_W       = 24;
    localparam int CH_W          = 8;
    localparam int PERIOD_W      = 16;
    localparam int PCT_W         = 7;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    // ramp and timing constants
    localparam logic [7:0]  PULSE_STEP       = 8'd10;
    localparam logic [7:0]  PULSE_TOP        = 8'd245;
    localparam logic [7:0]  PULSE_BOT        = 8'd20;
    localparam logic [7:0]  PULSE_FLOOR      = 8'd10;
    localparam logic [15:0] PULSE_INTERVAL   = 16'd20;
    localparam logic [7:0]  BREATHE_STEP     = 8'd4;
    localparam logic [7:0]  BREATHE_TOP      = 8'd251;
    localparam logic [7:0]  BREATHE_BOT      = 8'd24;
    localparam logic [7:0]  BREATHE_FLOOR    = 8'd20;
    localparam logic [15:0] BREATHE_INTERVAL = 16'd30;
    localparam logic [15:0] UPD_INTERVAL     = 16'd50;
    localparam logic [7:0]  RAMP_MAX         = 8'hFF;
    localparam logic [7:0]  LEVEL_DEFAULT    = 8'd128;
    localparam logic [23:0] UPD_COLOR        = 24'hFF00FF;
    localparam logic [6:0]  PCT_MAX          = 7'd100;
    localparam logic [15:0] FAST_DEFAULT     = 16'd100;
    localparam logic [15:0] SLOW_DEFAULT     = 16'd500;
    // 2^19 / 100, rounded up; exact quotient for dividends up to 25500
    localparam logic [12:0] RECIP_100        = 13'd5243;
    // mode code with no effect; a write of it is dropped
    localparam logic [2:0]  MODE_RSVD        = 3'd7;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_ON      = 3'd1,
        MODE_FAST    = 3'd2,
        MODE_SLOW    = 3'd3,
        MODE_PULSE   = 3'd4,
        MODE_BREATHE = 3'd5,
        MODE_UPDATE  = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        CFG_MODE   = 3'd0,
        CFG_COLOR  = 3'd1,
        CFG_BRIGHT = 3'd2,
        CFG_FAST   = 3'd3,
        CFG_SLOW   = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCALE,
        ST_MUL_R,
        ST_MUL_G,
        ST_MUL_B,
        ST_PUSH
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_LVL,
        MUL_RED,
        MUL_GRN,
        MUL_BLU
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     decide;
        mul_sel_t mul_sel;
        logic     push;
    } rle_cmd_t;

    typedef struct packed {
        logic emit;
        logic ramp;
        logic out_free;
    } rle_sts_t;

    // v*l/255 for 8-bit operands, exact over the whole 16-bit product range
    function automatic logic [7:0] scale255(input logic [7:0] v, input logic [7:0] l);
        logic [15:0] p;
        logic [16:0] s;
        begin
            p = {8'd0, v} * {8'd0, l};
            s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
            return s[15:8];
        end
    endfunction

    // percent*255/100 with saturation at 100 percent
    function automatic logic [7:0] level_from_pct(input logic [6:0] pct);
        logic [6:0]  p;
        logic [14:0] x;
        logic [27:0] q;
        begin
            p = (pct > PCT_MAX) ? PCT_MAX : pct;
            x = {8'd0, p} * 15'd255;
            q = {13'd0, x} * {15'd0, RECIP_100};
            return q[26:19];
        end
    endfunction

endpackage

/* sv/rle_if.sv */
// Channel interfaces of the RGB LED effect engine: tick input, LED result
// output and configuration write. Depends on rle_pkg.
interface rle_time_if import rle_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [TIME_IN_W-1:0] time_ms;
    modport source (output valid, output time_ms, input ready);
    modport sink   (input valid, input time_ms, output ready);
endinterface

interface rle_rgb_if import rle_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rle_cfg_if import rle_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

/* sv/rle_ctrl.sv */
// Sequencer of the effect engine: walks one tick request through decide,
// ramp scaling, three channel multiplies and the output push. Uses rle_pkg.
module rle_ctrl import rle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rle_sts_t sts,
    output rle_cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                priority if (!sts.emit) state_next = ST_IDLE;
                else if (sts.ramp)      state_next = ST_SCALE;
                else                    state_next = ST_MUL_R;
            end
            ST_SCALE:  state_next = ST_MUL_R;
            ST_MUL_R:  state_next = ST_MUL_G;
            ST_MUL_G:  state_next = ST_MUL_B;
            ST_MUL_B:  state_next = ST_PUSH;
            ST_PUSH:   if (sts.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.decide  = 1'b0;
        cmd.mul_sel = MUL_NONE;
        cmd.push    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECIDE: cmd.decide  = 1'b1;
            ST_SCALE:  cmd.mul_sel = MUL_LVL;
            ST_MUL_R:  cmd.mul_sel = MUL_RED;
            ST_MUL_G:  cmd.mul_sel = MUL_GRN;
            ST_MUL_B:  cmd.mul_sel = MUL_BLU;
            ST_PUSH:   cmd.push    = 1'b1;
            default:   in_ready    = 1'b0;
        endcase
    end

    a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_DECIDE)
        else $error("accepted request did not move to decide");

    a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH && !sts.out_free |=> state_reg == ST_PUSH)
        else $error("result dropped while output slot busy");

    a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DECIDE && !sts.emit |=> state_reg == ST_IDLE)
        else $error("silent tick did not return to idle");

endmodule

/* sv/rle_dp.sv */
// Datapath of the effect engine: configuration registers, effect state,
// shared 8x8 scale-by-level unit and the output register. Uses rle_pkg.
module rle_dp import rle_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [TIME_IN_W-1:0]  time_ms,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  rle_cmd_t              cmd,
    output rle_sts_t              sts,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [CH_W-1:0]       out_red,
    output logic [CH_W-1:0]       out_green,
    output logic [CH_W-1:0]       out_blue
);

    mode_t                mode_reg, mode_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic [PERIOD_W-1:0]  fast_reg, fast_next;
    logic [PERIOD_W-1:0]  slow_reg, slow_next;
    logic [7:0]           level_reg, level_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic                 lit_reg, lit_next;
    logic [7:0]           ramp_reg, ramp_next;
    logic                 rising_reg, rising_next;
    logic                 refresh_reg, refresh_next;
    logic                 out_valid_reg, out_valid_next;

    logic [COLOR_W-1:0]   op_color_reg, op_color_next;
    logic [7:0]           op_level_reg, op_level_next;
    logic [CH_W-1:0]      r_reg, r_next, g_reg, g_next, b_reg, b_next;
    logic [CH_W-1:0]      ored_reg, ogrn_reg, oblu_reg;

    logic [TIME_BITS-1:0] elapsed;
    logic [PERIOD_W-1:0]  interval;
    logic                 due;
    logic                 timed;
    logic                 emit;
    logic                 is_ramp;
    logic                 lit_new;
    logic [7:0]           ramp_new;
    logic                 rising_new;
    logic [7:0]           step, top_th, bot_th, floor_v;
    logic [2:0]           cfg_mode;
    logic [7:0]           mul_a, mul_b, mul_q;
    logic                 out_free;

    // decision for the captured tick
    always_comb
    begin
        elapsed = now_reg - last_reg;
        timed   = 1'b0;
        is_ramp = 1'b0;
        unique case (mode_reg)
            MODE_FAST:    begin interval = fast_reg;         timed = 1'b1; end
            MODE_SLOW:    begin interval = slow_reg;         timed = 1'b1; end
            MODE_UPDATE:  begin interval = UPD_INTERVAL;     timed = 1'b1; end
            MODE_PULSE:   begin interval = PULSE_INTERVAL;   is_ramp = 1'b1; end
            MODE_BREATHE: begin interval = BREATHE_INTERVAL; is_ramp = 1'b1; end
            default:      interval = '0;
        endcase
        due = (elapsed >= TIME_BITS'(interval));
        priority if (timed || is_ramp) emit = due;
        else if (mode_reg == MODE_OFF || mode_reg == MODE_ON) emit = refresh_reg;
        else emit = 1'b0;
        lit_new = !lit_reg;

        if (mode_reg == MODE_BREATHE)
        begin
            step = BREATHE_STEP; top_th = BREATHE_TOP;
            bot_th = BREATHE_BOT; floor_v = BREATHE_FLOOR;
        end
        else
        begin
            step = PULSE_STEP; top_th = PULSE_TOP;
            bot_th = PULSE_BOT; floor_v = PULSE_FLOOR;
        end
        priority if (rising_reg && ramp_reg >= top_th)
        begin
            ramp_new = RAMP_MAX; rising_new = 1'b0;
        end
        else if (rising_reg)
        begin
            ramp_new = ramp_reg + step; rising_new = 1'b1;
        end
        else if (ramp_reg <= bot_th)
        begin
            ramp_new = floor_v; rising_new = 1'b1;
        end
        else
        begin
            ramp_new = ramp_reg - step; rising_new = 1'b0;
        end
    end

    // shared scaling unit
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_LVL: begin mul_a = ramp_reg;            mul_b = level_reg;    end
            MUL_RED: begin mul_a = op_color_reg[23:16]; mul_b = op_level_reg; end
            MUL_GRN: begin mul_a = op_color_reg[15:8];  mul_b = op_level_reg; end
            MUL_BLU: begin mul_a = op_color_reg[7:0];   mul_b = op_level_reg; end
            default: begin mul_a = '0;                  mul_b = '0;           end
        endcase
        mul_q = scale255(mul_a, mul_b);
    end

    assign out_free = !out_valid_reg || out_ready;
    assign cfg_mode = cfg_data[2:0];

    always_comb
    begin
        mode_next      = mode_reg;
        color_next     = color_reg;
        fast_next      = fast_reg;
        slow_next      = slow_reg;
        level_next     = level_reg;
        last_next      = last_reg;
        now_next       = now_reg;
        lit_next       = lit_reg;
        ramp_next      = ramp_reg;
        rising_next    = rising_reg;
        refresh_next   = refresh_reg;
        out_valid_next = out_valid_reg;
        op_color_next  = op_color_reg;
        op_level_next  = op_level_reg;
        r_next         = r_reg;
        g_next         = g_reg;
        b_next         = b_reg;

        if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MODE:
                begin
                    // mode code seven and rewrites of the current mode do nothing
                    if (cfg_mode != MODE_RSVD && cfg_mode != mode_reg)
                    begin
                        mode_next    = mode_t'(cfg_mode);
                        last_next    = '0;
                        lit_next     = 1'b0;
                        refresh_next = 1'b1;
                        if (mode_t'(cfg_mode) == MODE_BREATHE)
                        begin
                            ramp_next   = RAMP_MAX;
                            rising_next = 1'b0;
                        end
                        else
                        begin
                            ramp_next   = '0;
                            rising_next = 1'b1;
                        end
                        if (level_reg == '0 && mode_t'(cfg_mode) != MODE_OFF)
                            level_next = LEVEL_DEFAULT;
                    end
                end
                CFG_COLOR:
                begin
                    color_next   = cfg_data[COLOR_W-1:0];
                    refresh_next = 1'b1;
                end
                CFG_BRIGHT:
                begin
                    level_next   = level_from_pct(cfg_data[PCT_W-1:0]);
                    refresh_next = 1'b1;
                end
                CFG_FAST: fast_next = cfg_data[PERIOD_W-1:0];
                CFG_SLOW: slow_next = cfg_data[PERIOD_W-1:0];
                default:  refresh_next = refresh_reg;
            endcase
        end

        if (cmd.capture)
            now_next = TIME_BITS'(time_ms);

        if (cmd.decide && emit)
        begin
            op_level_next = level_reg;
            if (mode_reg == MODE_OFF || mode_reg == MODE_ON)
            begin
                refresh_next  = 1'b0;
                op_color_next = (mode_reg == MODE_ON) ? color_reg : '0;
            end
            else if (timed)
            begin
                lit_next  = lit_new;
                last_next = now_reg;
                priority if (!lit_new)             op_color_next = '0;
                else if (mode_reg == MODE_UPDATE)  op_color_next = UPD_COLOR;
                else                               op_color_next = color_reg;
            end
            else
            begin
                ramp_next     = ramp_new;
                rising_next   = rising_new;
                last_next     = now_reg;
                op_color_next = color_reg;
            end
        end

        unique case (cmd.mul_sel)
            MUL_LVL: op_level_next = mul_q;
            MUL_RED: r_next = mul_q;
            MUL_GRN: g_next = mul_q;
            MUL_BLU: b_next = mul_q;
            default: r_next = r_reg;
        endcase

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.push && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_OFF;
            color_reg     <= '0;
            fast_reg      <= FAST_DEFAULT;
            slow_reg      <= SLOW_DEFAULT;
            level_reg     <= LEVEL_DEFAULT;
            last_reg      <= '0;
            now_reg       <= '0;
            lit_reg       <= 1'b0;
            ramp_reg      <= '0;
            rising_reg    <= 1'b1;
            refresh_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            color_reg     <= color_next;
            fast_reg      <= fast_next;
            slow_reg      <= slow_next;
            level_reg     <= level_next;
            last_reg      <= last_next;
            now_reg       <= now_next;
            lit_reg       <= lit_next;
            ramp_reg      <= ramp_next;
            rising_reg    <= rising_next;
            refresh_reg   <= refresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_color_reg <= op_color_next;
        op_level_reg <= op_level_next;
        r_reg        <= r_next;
        g_reg        <= g_next;
        b_reg        <= b_next;
        if (cmd.push && out_free)
        begin
            ored_reg <= r_reg;
            ogrn_reg <= g_reg;
            oblu_reg <= b_reg;
        end
    end

    assign sts.emit     = emit;
    assign sts.ramp     = is_ramp;
    assign sts.out_free = out_free;
    assign out_valid    = out_valid_reg;
    assign out_red      = ored_reg;
    assign out_green    = ogrn_reg;
    assign out_blue     = oblu_reg;

    a_push_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push && out_free |=> out_valid_reg)
        else $error("push did not load the output register");

    a_capture_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> now_reg == $past(TIME_BITS'(time_ms)))
        else $error("tick time not captured");

    a_toggle_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && emit && (timed || is_ramp) |=> last_reg == $past(now_reg))
        else $error("toggle time not updated on an emitted step");

endmodule

/* sv/rgb_led_effect_engine_top.sv */
// Top level of the RGB LED effect engine: ties the sequencer and datapath to
// the tick, LED and configuration channels. Uses rle_pkg, rle_if, rle_ctrl, rle_dp.
//
// Usage: one request on tick carries the current millisecond time stamp.
// Depending on the mode in effect, it yields zero or one result on led with
// the scaled red, green and blue drive values. Off and on modes answer only
// after a colour, brightness or mode write; blink, pulse and breathe modes
// answer once their interval has elapsed since the last step.
// Configuration writes on cfg (index 0 mode, 1 colour, 2 brightness percent,
// 3 fast period, 4 slow period) are always taken and belong in idle time.
// Sequence: a tick is taken in idle, decided in the next cycle; a result is
// then scaled by the level per colour channel and loaded into the output
// register at the push step (pulse and breathe scale the ramp by the level
// first). The shared 8x8 scale-by-level unit, used once per colour channel,
// sets this order: a new tick is taken only after the last one is through.
// A stalled receiver keeps the result in the output register; the next tick
// is still taken and waits at the push step until the register frees.
// Reset restores the register defaults (level 128, refresh pending) at once.
module rgb_led_effect_engine_top import rle_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input logic          clk,
    input logic          rst_n,
    rle_time_if.sink     tick,
    rle_rgb_if.source    led,
    rle_cfg_if.sink      cfg
);

    rle_cmd_t cmd;
    rle_sts_t sts;

    assign cfg.ready = 1'b1;

    rle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tick.valid),
        .in_ready (tick.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rle_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .time_ms   (tick.time_ms),
        .cfg_we    (cfg.valid && cfg.ready),
        .cfg_idx   (cfg.idx),
        .cfg_data  (cfg.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (led.ready),
        .out_valid (led.valid),
        .out_red   (led.red),
        .out_green (led.green),
        .out_blue  (led.blue)
    );

endmodule
